// ----- design/nvbf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the NVRAM bit-field access unit.
package nvbf_pkg;

  localparam int unsigned MaxAddrW = 8;

  typedef enum logic [1:0] {
    MODE_FIELD_RD = 2'd0,
    MODE_FIELD_WR = 2'd1,
    MODE_BYTE_RD  = 2'd2,
    MODE_BYTE_WR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_RESERVED = 2'd2,
    STATUS_WIDE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_RAW,
    S_ALIGN,
    S_DONE
  } state_e;

  typedef struct packed {
    mode_e        mode;
    logic [10:0]  bit_position;
    logic [6:0]   field_length;
    logic [63:0]  write_value;
    logic [7:0]   byte_addr;
  } req_t;

  typedef struct packed {
    logic [63:0]  read_value;
    status_e      status;
  } rsp_t;

  typedef struct packed {
    logic                rd_en;
    logic [MaxAddrW-1:0] raddr;
    logic                wr_en;
    logic [MaxAddrW-1:0] waddr;
    logic [7:0]          wdata;
  } mem_req_t;

endpackage

// ----- design/nvbf_mem.sv -----
`timescale 1ns / 1ps
// Byte store with registered read and per-entry valid bits.
module nvbf_mem #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nvbf_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);

  localparam int unsigned AddrW = $clog2(STORE_BYTES);

  logic [7:0]             mem_q [STORE_BYTES];
  logic [STORE_BYTES-1:0] vld_q;
  logic [7:0]             rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.waddr[AddrW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.waddr[AddrW-1:0]] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= vld_q[req_i.raddr[AddrW-1:0]] ? mem_q[req_i.raddr[AddrW-1:0]] : 8'h00;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/nvbf_seq.sv -----
`timescale 1ns / 1ps
// Request sequencer: field checks, byte walk with read-modify-write, raw byte access, result register.
module nvbf_seq #(
  parameter int unsigned STORE_BYTES    = 256,
  parameter int unsigned RESERVED_BYTES = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  nvbf_pkg::req_t     in_req_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nvbf_pkg::rsp_t     out_rsp_o,
  output nvbf_pkg::mem_req_t mem_req_o,
  input  logic [7:0]         mem_rdata_i
);

  localparam logic [11:0] TotalBits = 12'(8 * STORE_BYTES);
  localparam logic [10:0] RsvBits   = 11'(8 * RESERVED_BYTES);
  localparam logic [8:0]  StoreLim  = 9'(STORE_BYTES);

  nvbf_pkg::state_e  state_q, state_d;
  nvbf_pkg::req_t    req_q, req_d;
  nvbf_pkg::status_e stat_q, stat_d;
  nvbf_pkg::rsp_t    out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [7:0]        addr_q, addr_d;
  logic [71:0]       acc_q, acc_d;
  logic [71:0]       wdat_q, wdat_d;
  logic [71:0]       wmsk_q, wmsk_d;
  logic [6:0]        sh_q, sh_d;
  logic [63:0]       res_q, res_d;

  logic              range_err, rsv_err, wide_err, idx_err;
  logic [11:0]       end_bit;
  logic [2:0]        off;
  logic [7:0]        span;
  logic [3:0]        nbytes;
  logic [63:0]       lmask;
  logic [71:0]       shifted;

  function automatic logic [63:0] len_mask(logic [6:0] len);
    logic [63:0] m;
    if (len >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << len[5:0]) - 64'd1;
    end
    return m;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nvbf_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    stat_q <= stat_d;
    out_q  <= out_d;
    cnt_q  <= cnt_d;
    addr_q <= addr_d;
    acc_q  <= acc_d;
    wdat_q <= wdat_d;
    wmsk_q <= wmsk_d;
    sh_q   <= sh_d;
    res_q  <= res_d;
  end

  assign end_bit   = {1'b0, req_q.bit_position} + {5'b0, req_q.field_length};
  assign range_err = ({1'b0, req_q.bit_position} >= TotalBits) || (end_bit > TotalBits);
  assign rsv_err   = req_q.bit_position < RsvBits;
  assign wide_err  = req_q.field_length > 7'd64;
  assign idx_err   = {1'b0, req_q.byte_addr} >= StoreLim;
  assign off       = req_q.bit_position[2:0];
  assign span      = {5'b0, off} + {1'b0, req_q.field_length} + 8'd7;
  assign nbytes    = (req_q.field_length == 7'd0) ? 4'd0 : span[6:3];
  assign lmask     = len_mask(req_q.field_length);
  assign shifted   = acc_q >> sh_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    stat_d      = stat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    acc_d       = acc_q;
    wdat_d      = wdat_q;
    wmsk_d      = wmsk_q;
    sh_d        = sh_q;
    res_d       = res_q;
    mem_req_o   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      nvbf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          state_d = nvbf_pkg::S_CHECK;
        end
      end
      nvbf_pkg::S_CHECK: begin
        res_d  = '0;
        stat_d = nvbf_pkg::STATUS_OK;
        if (req_q.mode inside {nvbf_pkg::MODE_FIELD_RD, nvbf_pkg::MODE_FIELD_WR}) begin
          if (range_err) begin
            stat_d  = nvbf_pkg::STATUS_RANGE;
            state_d = nvbf_pkg::S_DONE;
          end else if (rsv_err) begin
            stat_d  = nvbf_pkg::STATUS_RESERVED;
            state_d = nvbf_pkg::S_DONE;
          end else if (wide_err) begin
            stat_d  = nvbf_pkg::STATUS_WIDE;
            state_d = nvbf_pkg::S_DONE;
          end else if (nbytes == 4'd0) begin
            state_d = nvbf_pkg::S_DONE;
          end else begin
            cnt_d           = nbytes;
            addr_d          = req_q.bit_position[10:3];
            acc_d           = '0;
            wdat_d          = {8'b0, req_q.write_value & lmask} << off;
            wmsk_d          = {8'b0, lmask} << off;
            sh_d            = 7'(7'd72 - {nbytes, 3'b000} + {4'b0, off});
            mem_req_o.rd_en = 1'b1;
            mem_req_o.raddr = req_q.bit_position[10:3];
            state_d         = nvbf_pkg::S_RUN;
          end
        end else if (idx_err) begin
          stat_d  = nvbf_pkg::STATUS_RANGE;
          state_d = nvbf_pkg::S_DONE;
        end else if (req_q.mode == nvbf_pkg::MODE_BYTE_RD) begin
          mem_req_o.rd_en = 1'b1;
          mem_req_o.raddr = req_q.byte_addr;
          state_d         = nvbf_pkg::S_RAW;
        end else begin
          mem_req_o.wr_en = 1'b1;
          mem_req_o.waddr = req_q.byte_addr;
          mem_req_o.wdata = req_q.write_value[7:0];
          state_d         = nvbf_pkg::S_DONE;
        end
      end
      nvbf_pkg::S_RUN: begin
        acc_d = {mem_rdata_i, acc_q[71:8]};
        if (req_q.mode == nvbf_pkg::MODE_FIELD_WR) begin
          mem_req_o.wr_en = 1'b1;
          mem_req_o.waddr = addr_q;
          mem_req_o.wdata = (mem_rdata_i & ~wmsk_q[7:0]) | (wdat_q[7:0] & wmsk_q[7:0]);
          wdat_d          = wdat_q >> 8;
          wmsk_d          = wmsk_q >> 8;
        end
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          state_d = (req_q.mode == nvbf_pkg::MODE_FIELD_RD) ? nvbf_pkg::S_ALIGN
                                                             : nvbf_pkg::S_DONE;
        end else begin
          addr_d          = addr_q + 8'd1;
          mem_req_o.rd_en = 1'b1;
          mem_req_o.raddr = addr_q + 8'd1;
        end
      end
      nvbf_pkg::S_RAW: begin
        res_d   = {56'b0, mem_rdata_i};
        state_d = nvbf_pkg::S_DONE;
      end
      nvbf_pkg::S_ALIGN: begin
        res_d   = shifted[63:0] & lmask;
        state_d = nvbf_pkg::S_DONE;
      end
      nvbf_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.read_value = res_q;
          out_d.status     = stat_q;
          state_d          = nvbf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = nvbf_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != nvbf_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ----- design/nvram_bit_field_access_unit.sv -----
`timescale 1ns / 1ps
// Top level of the NVRAM bit-field access unit: sequencer and byte store.
//
//   channel  dir  handshake              payload
//   request  in   in_valid_i/in_stall_o   in_req_i  (nvbf_pkg::req_t)
//   result   out  out_valid_o/out_stall_i out_rsp_o (nvbf_pkg::rsp_t)
//
// A field request spanning n bytes (n up to 9) passes from accept through the check
// state, one store access per byte, an align step for reads, and the result register.
// Raw byte reads add one store read; raw writes and rejected requests skip to the result.
// Reset clears per-byte valid bits at once; unwritten bytes read as zero.
// The request side stalls while a request is in flight; the result register lets the
// next request enter while the previous result is still held.
module nvram_bit_field_access_unit #(
  parameter int unsigned STORE_BYTES    = 256,
  parameter int unsigned RESERVED_BYTES = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  nvbf_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output nvbf_pkg::rsp_t out_rsp_o
);

  nvbf_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rdata;

  nvbf_seq #(
    .STORE_BYTES   (STORE_BYTES),
    .RESERVED_BYTES(RESERVED_BYTES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .mem_req_o  (mem_req),
    .mem_rdata_i(mem_rdata)
  );

  nvbf_mem #(
    .STORE_BYTES(STORE_BYTES)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request side open right after accept");

  a_error_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != nvbf_pkg::STATUS_OK) |-> (out_rsp_o.read_value == '0))
    else $error("failed request returns nonzero value");

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.waddr != mem_req.raddr))
    else $error("read and write hit the same store entry");

  a_mem_idle_when_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!mem_req.wr_en && !mem_req.rd_en))
    else $error("store access without a request in flight");

endmodule
